FILE: rtl/multi_voice_nibble_sample_mixer_defines.svh
// Assertion macros shared by the sample mixer RTL.
`ifndef MULTI_VOICE_NIBBLE_SAMPLE_MIXER_DEFINES_SVH
`define MULTI_VOICE_NIBBLE_SAMPLE_MIXER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MVNSM_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MVNSM_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mvnsm_pkg.sv
// Package with the sample mixer's constants, types and level table.
package mvnsm_pkg;

    localparam int VOICE_COUNT = 8;
    localparam int VOICE_W     = 3;
    localparam int STORE_BYTES = 16384;
    localparam int ADDR_W      = 14;
    localparam int RATE_W      = 16;
    localparam int LEN_W       = 16;
    localparam int CYC_W       = 16;
    localparam int DEBT_W      = 18;
    localparam int MOD_W       = 24;
    localparam int FRAC_W      = 24;
    localparam int PERIOD_W    = 16;
    localparam int HALVE_W     = 5;
    localparam int PROD_W      = DEBT_W + RATE_W;
    localparam int DIVD_W      = PROD_W + 2;
    localparam int DCNT_W      = $clog2(DIVD_W + 1);
    localparam int NCNT_W      = $clog2(VOICE_COUNT + 1);
    localparam int ACC_W       = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;

    localparam logic [RATE_W-1:0]     MAX_RATE   = RATE_W'(48000);
    localparam logic [3:0]            MIDPOINT   = 4'd8;
    localparam logic [MOD_W-1:0]      BUS_HZ_RST = MOD_W'(1500000);
    localparam logic [PERIOD_W-1:0]   PERIOD_RST = PERIOD_W'(187);
    localparam logic [HALVE_W-1:0]    HALVE_RST  = HALVE_W'(3);

    localparam logic [2:0] ACT_STORE = 3'd0;
    localparam logic [2:0] ACT_START = 3'd1;
    localparam logic [2:0] ACT_STOP  = 3'd2;
    localparam logic [2:0] ACT_QUERY = 3'd3;
    localparam logic [2:0] ACT_FRAME = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_BUS_HZ = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALVE  = 2'd2;

    typedef struct packed {
        logic [2:0]        action;
        logic [ADDR_W-1:0] address;
        logic [7:0]        data_byte;
        logic [VOICE_W-1:0] voice;
        logic              all_voices;
        logic [RATE_W-1:0] sample_rate;
        logic [LEN_W-1:0]  sample_count;
        logic              loop;
        logic [CYC_W-1:0]  list_cycle;
    } cmd_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [LEN_W-1:0]  length;
        logic [RATE_W-1:0] rate;
        logic [LEN_W-1:0]  cursor;
        logic [FRAC_W-1:0] fraction;
        logic              repeat_en;
    } voice_rec_t;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [MOD_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIVD_W-1:0] quotient;
        logic [MOD_W-1:0]  remainder;
    } div_rsp_t;

    function automatic logic [3:0] level_map(input logic [3:0] idx);
        logic [3:0] lvl;
        unique case (idx)
            4'd0:    lvl = 4'd0;
            4'd1:    lvl = 4'd5;
            4'd2:    lvl = 4'd7;
            4'd3:    lvl = 4'd8;
            4'd4:    lvl = 4'd9;
            4'd5:    lvl = 4'd10;
            4'd6:    lvl = 4'd10;
            4'd7:    lvl = 4'd11;
            4'd8:    lvl = 4'd12;
            4'd9:    lvl = 4'd12;
            4'd10:   lvl = 4'd13;
            4'd11:   lvl = 4'd13;
            4'd12:   lvl = 4'd14;
            4'd13:   lvl = 4'd14;
            4'd14:   lvl = 4'd15;
            default: lvl = 4'd15;
        endcase
        return lvl;
    endfunction

    function automatic logic [NCNT_W-1:0] count_ones(input logic [VOICE_COUNT-1:0] bits);
        logic [NCNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < VOICE_COUNT; i++)
        begin
            n = n + NCNT_W'(bits[i]);
        end
        return n;
    endfunction

endpackage

FILE: rtl/mvnsm_if.sv
// Handshake interfaces for the command, result and configuration channels.
interface mvnsm_cmd_if;
    logic                              valid;
    logic                              ready;
    logic [2:0]                        action;
    logic [mvnsm_pkg::ADDR_W-1:0]      address;
    logic [7:0]                        data_byte;
    logic [mvnsm_pkg::VOICE_W-1:0]     voice;
    logic                              all_voices;
    logic [mvnsm_pkg::RATE_W-1:0]      sample_rate;
    logic [mvnsm_pkg::LEN_W-1:0]       sample_count;
    logic                              loop;
    logic [mvnsm_pkg::CYC_W-1:0]       list_cycle;

    modport source (output valid, action, address, data_byte, voice, all_voices,
                    sample_rate, sample_count, loop, list_cycle, input ready);
    modport sink   (input valid, action, address, data_byte, voice, all_voices,
                    sample_rate, sample_count, loop, list_cycle, output ready);
endinterface

interface mvnsm_res_if;
    logic       valid;
    logic       ready;
    logic       sample_due;
    logic [3:0] level;
    logic       voice_playing;
    logic       any_playing;

    modport source (output valid, sample_due, level, voice_playing, any_playing,
                    input ready);
    modport sink   (input valid, sample_due, level, voice_playing, any_playing,
                    output ready);
endinterface

interface mvnsm_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [mvnsm_pkg::CFG_IDX_W-1:0]     index;
    logic [mvnsm_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/mvnsm_div.sv
// Restoring divider, one quotient bit per cycle.
module mvnsm_div
(
    input  logic                clk,
    input  logic                rst_n,
    input  mvnsm_pkg::div_req_t req,
    output mvnsm_pkg::div_rsp_t rsp
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [mvnsm_pkg::DCNT_W-1:0]      cnt_reg;
    logic [mvnsm_pkg::DIVD_W-1:0]      quo_reg;
    logic [mvnsm_pkg::MOD_W-1:0]       rem_reg;
    logic [mvnsm_pkg::MOD_W-1:0]       dsr_reg;
    logic [mvnsm_pkg::MOD_W:0]         trial;
    logic                              fits;

    assign trial = {rem_reg, quo_reg[mvnsm_pkg::DIVD_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= mvnsm_pkg::DCNT_W'(mvnsm_pkg::DIVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == mvnsm_pkg::DCNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[mvnsm_pkg::DIVD_W-2:0], fits};
            rem_reg <= fits ? mvnsm_pkg::MOD_W'(trial - {1'b0, dsr_reg})
                            : trial[mvnsm_pkg::MOD_W-1:0];
        end
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

FILE: rtl/multi_voice_nibble_sample_mixer.sv
// Top level of the multi-voice 4-bit sample mixer.
//
// Usage: commands arrive as words on cmd (store byte, start voice, stop,
// position query, frame end) and every command gives exactly one result word
// on res. Configuration words (bus_hz, sample_period, halve_threshold) go in on
// cfg, which is always ready; write them only while the block is idle.
// A store, start, stop, frame end or a query that gives no level passes from the
// execute state to the output state and is then presented on res. A query that
// settles a level walks the eight voices in turn; each active voice reads its
// record and uses the shared divider, which yields one quotient bit per cycle
// over a 36-bit dividend, and uses it a second time when a looped voice wraps.
// One command is worked on at a time; cmd is ready again once the previous
// result has been placed in the output register, so the next command is taken
// while a result still waits. If res stalls, the block holds the finished
// result and finishes the next command up to its output stage, then waits.
// Reset clears all voices, the cycle debt and the last seen cycle, and loads
// the configuration defaults; the sample store is not cleared.
`include "multi_voice_nibble_sample_mixer_defines.svh"

module multi_voice_nibble_sample_mixer
(
    input  logic              clk,
    input  logic              rst_n,
    mvnsm_cmd_if.sink         cmd,
    mvnsm_res_if.source       res,
    mvnsm_cfg_if.sink         cfg
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EXEC  = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_RDREC = 4'd3;
    localparam logic [3:0] S_ADD   = 4'd4;
    localparam logic [3:0] S_DIV1  = 4'd5;
    localparam logic [3:0] S_POS   = 4'd6;
    localparam logic [3:0] S_DIV2  = 4'd7;
    localparam logic [3:0] S_WRREC = 4'd8;
    localparam logic [3:0] S_STRD  = 4'd9;
    localparam logic [3:0] S_NEXT  = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    // Configuration registers.
    logic [mvnsm_pkg::MOD_W-1:0]    bus_hz_reg;
    logic [mvnsm_pkg::PERIOD_W-1:0] period_reg;
    logic [mvnsm_pkg::HALVE_W-1:0]  halve_reg;

    // Control and working registers.
    logic [3:0]                          state_reg, state_next;
    mvnsm_pkg::cmd_t                     item_reg;
    logic [mvnsm_pkg::VOICE_COUNT-1:0]   active_reg, active_next;
    logic [mvnsm_pkg::DEBT_W-1:0]        debt_reg, debt_next;
    logic [mvnsm_pkg::CYC_W-1:0]         last_reg, last_next;
    logic [mvnsm_pkg::VOICE_W-1:0]       v_reg, v_next;
    logic [mvnsm_pkg::PROD_W-1:0]        prod_reg, prod_next;
    logic [mvnsm_pkg::DIVD_W-1:0]        pos_reg, pos_next;
    logic [mvnsm_pkg::FRAC_W-1:0]        frac_reg, frac_next;
    logic signed [mvnsm_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic                                due_reg, due_next;
    logic [3:0]                          level_reg, level_next;

    // Output register.
    logic       res_valid_reg;
    logic       res_due_reg;
    logic [3:0] res_level_reg;
    logic       res_vp_reg;
    logic       res_any_reg;
    logic       res_load;

    // Voice record memory and sample store.
    mvnsm_pkg::voice_rec_t rec_mem [mvnsm_pkg::VOICE_COUNT];
    mvnsm_pkg::voice_rec_t rec_q;
    mvnsm_pkg::voice_rec_t rec_wdata;
    logic                  rec_we;
    logic                  rec_re;
    logic [mvnsm_pkg::VOICE_W-1:0] rec_waddr;

    logic [7:0] store_mem [mvnsm_pkg::STORE_BYTES];
    logic [7:0] store_q;
    logic       store_we;
    logic       store_re;
    logic [mvnsm_pkg::ADDR_W-1:0] store_raddr;

    mvnsm_pkg::div_req_t div_req;
    mvnsm_pkg::div_rsp_t div_rsp;

    // Per-command helpers.
    logic [mvnsm_pkg::MOD_W-1:0]   modulus;
    logic [mvnsm_pkg::CYC_W-1:0]   query_gap;
    logic [mvnsm_pkg::DEBT_W-1:0]  query_debt;
    logic [mvnsm_pkg::DEBT_W-1:0]  frame_debt;
    logic                          start_ok;
    logic [3:0]                    nibble;
    logic signed [mvnsm_pkg::ACC_W-1:0] half_acc;
    logic signed [mvnsm_pkg::ACC_W-1:0] mix;
    logic [mvnsm_pkg::NCNT_W-1:0]  voices_on;

    mvnsm_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign cmd.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    // A zero modulus behaves as one.
    assign modulus = (bus_hz_reg == '0) ? mvnsm_pkg::MOD_W'(1) : bus_hz_reg;

    // A cycle position below the last one seen counts from zero.
    assign query_gap  = (item_reg.list_cycle >= last_reg) ? item_reg.list_cycle - last_reg
                                                          : item_reg.list_cycle;
    assign query_debt = debt_reg + mvnsm_pkg::DEBT_W'(query_gap);
    assign frame_debt = debt_reg + ((item_reg.list_cycle >= last_reg)
                        ? mvnsm_pkg::DEBT_W'(item_reg.list_cycle - last_reg)
                        : mvnsm_pkg::DEBT_W'(0));

    assign start_ok = (item_reg.sample_rate != '0) &&
                      (item_reg.sample_rate <= mvnsm_pkg::MAX_RATE) &&
                      (item_reg.sample_count != '0);

    assign nibble = pos_reg[0] ? store_q[7:4] : store_q[3:0];

    // The mix is halved with truncation towards zero when too many voices play.
    assign voices_on = mvnsm_pkg::count_ones(active_reg);
    assign half_acc  = (acc_reg + ((acc_reg < 0) ? mvnsm_pkg::ACC_W'(1)
                                                 : mvnsm_pkg::ACC_W'(0))) >>> 1;
    assign mix = ((mvnsm_pkg::HALVE_W'(voices_on) > halve_reg) ? half_acc : acc_reg)
                 + mvnsm_pkg::ACC_W'(signed'({4'b0, mvnsm_pkg::MIDPOINT}));

    assign res_load = (state_reg == S_OUT) && (!res_valid_reg || res.ready);

    always_comb
    begin
        state_next  = state_reg;
        active_next = active_reg;
        debt_next   = debt_reg;
        last_next   = last_reg;
        v_next      = v_reg;
        prod_next   = prod_reg;
        pos_next    = pos_reg;
        frac_next   = frac_reg;
        acc_next    = acc_reg;
        due_next    = due_reg;
        level_next  = level_reg;

        rec_we      = 1'b0;
        rec_re      = 1'b0;
        rec_waddr   = v_reg;
        rec_wdata   = rec_q;
        store_we    = 1'b0;
        store_re    = 1'b0;
        store_raddr = rec_q.start + pos_reg[mvnsm_pkg::ADDR_W:1];

        div_req.start    = 1'b0;
        div_req.dividend = mvnsm_pkg::DIVD_W'(frac_reg) + mvnsm_pkg::DIVD_W'(prod_reg);
        div_req.divisor  = modulus;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                due_next   = 1'b0;
                level_next = 4'd0;
                state_next = S_OUT;
                priority case (item_reg.action)
                    mvnsm_pkg::ACT_STORE:
                    begin
                        store_we = 1'b1;
                    end
                    mvnsm_pkg::ACT_START:
                    begin
                        if (start_ok)
                        begin
                            rec_we              = 1'b1;
                            rec_waddr           = item_reg.voice;
                            rec_wdata.start     = item_reg.address;
                            rec_wdata.length    = item_reg.sample_count;
                            rec_wdata.rate      = item_reg.sample_rate;
                            rec_wdata.cursor    = '0;
                            rec_wdata.fraction  = '0;
                            rec_wdata.repeat_en = item_reg.loop;
                            active_next[item_reg.voice] = 1'b1;
                        end
                    end
                    mvnsm_pkg::ACT_STOP:
                    begin
                        if (item_reg.all_voices)
                        begin
                            active_next = '0;
                        end
                        else
                        begin
                            active_next[item_reg.voice] = 1'b0;
                        end
                    end
                    mvnsm_pkg::ACT_QUERY:
                    begin
                        last_next = item_reg.list_cycle;
                        if (active_reg != '0)
                        begin
                            debt_next = query_debt;
                            if (query_debt >= mvnsm_pkg::DEBT_W'(period_reg))
                            begin
                                v_next     = '0;
                                acc_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                    end
                    mvnsm_pkg::ACT_FRAME:
                    begin
                        last_next = '0;
                        if (frame_debt > mvnsm_pkg::DEBT_W'({period_reg, 1'b0}))
                        begin
                            debt_next = mvnsm_pkg::DEBT_W'(period_reg);
                        end
                        else
                        begin
                            debt_next = frame_debt;
                        end
                    end
                    default:
                    begin
                        state_next = S_OUT;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (active_reg[v_reg])
                begin
                    rec_re     = 1'b1;
                    state_next = S_RDREC;
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end
            S_RDREC:
            begin
                prod_next  = debt_reg * rec_q.rate;
                frac_next  = rec_q.fraction;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                div_req.start = 1'b1;
                state_next    = S_DIV1;
            end
            S_DIV1:
            begin
                if (div_rsp.done)
                begin
                    pos_next   = mvnsm_pkg::DIVD_W'(rec_q.cursor) + div_rsp.quotient;
                    frac_next  = mvnsm_pkg::FRAC_W'(div_rsp.remainder);
                    state_next = S_POS;
                end
            end
            S_POS:
            begin
                div_req.dividend = pos_reg;
                div_req.divisor  = mvnsm_pkg::MOD_W'(rec_q.length);
                if (pos_reg >= mvnsm_pkg::DIVD_W'(rec_q.length))
                begin
                    if (rec_q.repeat_en)
                    begin
                        div_req.start = 1'b1;
                        state_next    = S_DIV2;
                    end
                    else
                    begin
                        active_next[v_reg] = 1'b0;
                        pos_next           = '0;
                        state_next         = S_WRREC;
                    end
                end
                else
                begin
                    state_next = S_WRREC;
                end
            end
            S_DIV2:
            begin
                if (div_rsp.done)
                begin
                    pos_next   = mvnsm_pkg::DIVD_W'(div_rsp.remainder);
                    state_next = S_WRREC;
                end
            end
            S_WRREC:
            begin
                rec_we             = 1'b1;
                rec_wdata.cursor   = pos_reg[mvnsm_pkg::LEN_W-1:0];
                rec_wdata.fraction = frac_reg;
                if (active_reg[v_reg])
                begin
                    store_re   = 1'b1;
                    state_next = S_STRD;
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end
            S_STRD:
            begin
                acc_next   = acc_reg + mvnsm_pkg::ACC_W'(signed'({4'b0, nibble}))
                             - mvnsm_pkg::ACC_W'(signed'({4'b0, mvnsm_pkg::MIDPOINT}));
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                if (v_reg == mvnsm_pkg::VOICE_W'(mvnsm_pkg::VOICE_COUNT - 1))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    v_next     = v_reg + 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_FIN:
            begin
                // With no voice left the mix is zero, which maps to the midpoint.
                debt_next = '0;
                due_next  = 1'b1;
                if (mix < 0)
                begin
                    level_next = mvnsm_pkg::level_map(4'd0);
                end
                else if (mix > mvnsm_pkg::ACC_W'(15))
                begin
                    level_next = mvnsm_pkg::level_map(4'd15);
                end
                else
                begin
                    level_next = mvnsm_pkg::level_map(mix[3:0]);
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (res_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= '0;
            debt_reg      <= '0;
            last_reg      <= '0;
            res_valid_reg <= 1'b0;
            bus_hz_reg    <= mvnsm_pkg::BUS_HZ_RST;
            period_reg    <= mvnsm_pkg::PERIOD_RST;
            halve_reg     <= mvnsm_pkg::HALVE_RST;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            debt_reg   <= debt_next;
            last_reg   <= last_next;
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (cfg.valid)
            begin
                priority case (cfg.index)
                    mvnsm_pkg::REG_BUS_HZ: bus_hz_reg <= cfg.data;
                    mvnsm_pkg::REG_PERIOD: period_reg <= cfg.data[mvnsm_pkg::PERIOD_W-1:0];
                    mvnsm_pkg::REG_HALVE:  halve_reg  <= cfg.data[mvnsm_pkg::HALVE_W-1:0];
                    default:               halve_reg  <= halve_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg     <= v_next;
        prod_reg  <= prod_next;
        pos_reg   <= pos_next;
        frac_reg  <= frac_next;
        acc_reg   <= acc_next;
        due_reg   <= due_next;
        level_reg <= level_next;
        if (cmd.valid && cmd.ready)
        begin
            item_reg.action       <= cmd.action;
            item_reg.address      <= cmd.address;
            item_reg.data_byte    <= cmd.data_byte;
            item_reg.voice        <= cmd.voice;
            item_reg.all_voices   <= cmd.all_voices;
            item_reg.sample_rate  <= cmd.sample_rate;
            item_reg.sample_count <= cmd.sample_count;
            item_reg.loop         <= cmd.loop;
            item_reg.list_cycle   <= cmd.list_cycle;
        end
        if (res_load)
        begin
            res_due_reg   <= due_reg;
            res_level_reg <= level_reg;
            res_vp_reg    <= active_reg[item_reg.voice];
            res_any_reg   <= |active_reg;
        end
    end

    // Voice records: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (rec_we)
        begin
            rec_mem[rec_waddr] <= rec_wdata;
        end
        if (rec_re)
        begin
            rec_q <= rec_mem[v_reg];
        end
    end

    // Sample store: byte writes from the command, registered reads for the mix.
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[item_reg.address] <= item_reg.data_byte;
        end
        if (store_re)
        begin
            store_q <= store_mem[store_raddr];
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.sample_due    = res_due_reg;
    assign res.level         = res_level_reg;
    assign res.voice_playing = res_vp_reg;
    assign res.any_playing   = res_any_reg;

    `MVNSM_CHECK_NEXT(a_accept_exec, cmd.valid && cmd.ready, state_reg == S_EXEC, "accepted word not executed")
    `MVNSM_CHECK(a_div_idle_start, div_req.start, !div_rsp.busy, "divider started while busy")
    `MVNSM_CHECK(a_due_query_only, res_load && due_reg, item_reg.action == mvnsm_pkg::ACT_QUERY, "level due outside a query")
    `MVNSM_CHECK(a_level_zero, res.valid && !res.sample_due, res.level == 4'd0, "level set without a due sample")

endmodule

FILE: test/multi_voice_nibble_sample_mixer_test.sv
// Self-checking testbench for the multi-voice nibble sample mixer.
`timescale 1ns / 100ps

module multi_voice_nibble_sample_mixer_test;

    // Action codes that the block does not know; it must answer them with an idle result.
    localparam logic [2:0] ACT_SPARE_A = 3'd5;
    localparam logic [2:0] ACT_SPARE_B = 3'd6;
    localparam logic [2:0] ACT_SPARE_C = 3'd7;

    // Logarithmic attenuator levels, indexed by the clamped mix.
    localparam logic [3:0] ATTEN_LEVELS [16] =
        '{4'd0, 4'd5, 4'd7, 4'd8, 4'd9, 4'd10, 4'd10, 4'd11,
          4'd12, 4'd12, 4'd13, 4'd13, 4'd14, 4'd14, 4'd15, 4'd15};

    // Stores to 0 .. WINDOW-1 are made before any random start, and every
    // started voice reads only inside that window.
    localparam int WINDOW = 160;
    localparam int DRAIN_CYCLES = 700;

    typedef struct packed {
        logic       sample_due;
        logic [3:0] level;
        logic       voice_playing;
        logic       any_playing;
    } mix_word_t;

    // One row of the directed table. When typed is set, the row's expected
    // word is checked in place of the predicted one.
    typedef struct packed {
        mvnsm_pkg::cmd_t c;
        logic            typed;
        mix_word_t       want;
    } directed_row_t;

    logic clk;
    logic rst_n;

    mvnsm_cmd_if cmd_ch ();
    mvnsm_res_if res_ch ();
    mvnsm_cfg_if cfg_ch ();

    multi_voice_nibble_sample_mixer dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    // Predictor state: the configuration and a copy of every voice.
    int unsigned                  p_bus_hz;
    int unsigned                  p_period;
    int unsigned                  p_halve;
    logic [7:0]                   p_store [mvnsm_pkg::STORE_BYTES];
    logic [mvnsm_pkg::ADDR_W-1:0] p_start [mvnsm_pkg::VOICE_COUNT];
    int unsigned                  p_length [mvnsm_pkg::VOICE_COUNT];
    int unsigned                  p_rate [mvnsm_pkg::VOICE_COUNT];
    int unsigned                  p_cursor [mvnsm_pkg::VOICE_COUNT];
    longint unsigned              p_fraction [mvnsm_pkg::VOICE_COUNT];
    bit                           p_repeat [mvnsm_pkg::VOICE_COUNT];
    bit                           p_active [mvnsm_pkg::VOICE_COUNT];
    int unsigned                  p_active_count;
    int unsigned                  p_debt;
    int unsigned                  p_last_cycle;

    mix_word_t pending_words [$];
    int        mismatches;
    int        send_idle_pct;
    int        recv_stall_pct;
    logic [mvnsm_pkg::CYC_W-1:0] list_pos;

    always #5 clk = ~clk;

    initial
    begin
        #50ms;
        $display("FAILURE");
        $finish;
    end

    // Receiver: ready is redrawn at every falling edge.
    always @(negedge clk)
    begin
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result checker: every accepted word is matched against the oldest prediction.
    always @(posedge clk)
    begin
        mix_word_t got;
        mix_word_t exp_w;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got = '{res_ch.sample_due, res_ch.level, res_ch.voice_playing,
                    res_ch.any_playing};
            if (pending_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %p", got);
            end
            else
            begin
                exp_w = pending_words.pop_front();
                if (got !== exp_w)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p, got %p", exp_w, got);
                end
            end
        end
    end

    function automatic logic [3:0] nibble_at(int v);
        logic [7:0] b;
        b = p_store[(p_start[v] + (p_cursor[v] >> 1)) % mvnsm_pkg::STORE_BYTES];
        return p_cursor[v][0] ? b[7:4] : b[3:0];
    endfunction

    // Advances every active voice by a number of bus cycles, with an exact remainder.
    function automatic void advance_voices(int unsigned cycles);
        longint unsigned modulus;
        longint unsigned total;
        longint unsigned pos;
        modulus = (p_bus_hz == 0) ? 1 : p_bus_hz;
        for (int v = 0; v < mvnsm_pkg::VOICE_COUNT; v++)
        begin
            if (p_active[v])
            begin
                total = p_fraction[v] + longint'(cycles) * p_rate[v];
                pos = p_cursor[v] + total / modulus;
                p_fraction[v] = total % modulus;
                if (pos >= p_length[v])
                begin
                    if (p_repeat[v] && p_length[v] != 0)
                        pos = pos % p_length[v];
                    else
                    begin
                        p_active[v] = 0;
                        p_active_count--;
                        pos = 0;
                    end
                end
                p_cursor[v] = 32'(pos);
            end
        end
    endfunction

    function automatic logic [3:0] mixed_level();
        int acc;
        int n;
        acc = 0;
        n = 0;
        for (int v = 0; v < mvnsm_pkg::VOICE_COUNT; v++)
        begin
            if (p_active[v])
            begin
                acc += int'(nibble_at(v)) - int'(mvnsm_pkg::MIDPOINT);
                n++;
            end
        end
        // Integer division truncates towards zero, as the mix requires.
        if (n > p_halve)
            acc = acc / 2;
        acc += int'(mvnsm_pkg::MIDPOINT);
        if (acc < 0)
            acc = 0;
        if (acc > 15)
            acc = 15;
        return ATTEN_LEVELS[acc];
    endfunction

    // Applies one command word to the predictor and returns the word it must answer with.
    function automatic mix_word_t predict_mix(mvnsm_pkg::cmd_t c);
        mix_word_t r;
        int unsigned d;
        r = '0;
        case (c.action)
            mvnsm_pkg::ACT_STORE: p_store[c.address] = c.data_byte;
            mvnsm_pkg::ACT_START:
            begin
                if (c.sample_rate != 0 && c.sample_rate <= mvnsm_pkg::MAX_RATE &&
                    c.sample_count != 0)
                begin
                    if (!p_active[c.voice])
                        p_active_count++;
                    p_start[c.voice]    = c.address;
                    p_length[c.voice]   = c.sample_count;
                    p_rate[c.voice]     = c.sample_rate;
                    p_cursor[c.voice]   = 0;
                    p_fraction[c.voice] = 0;
                    p_repeat[c.voice]   = c.loop;
                    p_active[c.voice]   = 1;
                end
            end
            mvnsm_pkg::ACT_STOP:
            begin
                for (int v = 0; v < mvnsm_pkg::VOICE_COUNT; v++)
                begin
                    if ((c.all_voices || v == c.voice) && p_active[v])
                    begin
                        p_active[v] = 0;
                        p_active_count--;
                    end
                end
            end
            mvnsm_pkg::ACT_QUERY:
            begin
                if (p_active_count == 0)
                    p_last_cycle = c.list_cycle;
                else
                begin
                    // A position behind the last one seen counts from zero.
                    d = (c.list_cycle >= p_last_cycle) ? c.list_cycle - p_last_cycle
                                                       : c.list_cycle;
                    p_last_cycle = c.list_cycle;
                    p_debt += d;
                    if (p_debt >= p_period)
                    begin
                        advance_voices(p_debt);
                        p_debt = 0;
                        r.sample_due = 1;
                        r.level = (p_active_count == 0)
                                  ? ATTEN_LEVELS[mvnsm_pkg::MIDPOINT] : mixed_level();
                    end
                end
            end
            mvnsm_pkg::ACT_FRAME:
            begin
                if (c.list_cycle >= p_last_cycle)
                    p_debt += c.list_cycle - p_last_cycle;
                p_last_cycle = 0;
                if (p_debt > p_period * 2)
                    p_debt = p_period;
            end
            default: ;
        endcase
        r.voice_playing = p_active[c.voice];
        r.any_playing = (p_active_count != 0);
        return r;
    endfunction

    // Sends one command word with the current idling, then records its expected answer.
    task automatic send_cmd(mvnsm_pkg::cmd_t c, bit typed = 0, mix_word_t want = '0);
        mix_word_t p;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid        <= 1'b1;
        cmd_ch.action       <= c.action;
        cmd_ch.address      <= c.address;
        cmd_ch.data_byte    <= c.data_byte;
        cmd_ch.voice        <= c.voice;
        cmd_ch.all_voices   <= c.all_voices;
        cmd_ch.sample_rate  <= c.sample_rate;
        cmd_ch.sample_count <= c.sample_count;
        cmd_ch.loop         <= c.loop;
        cmd_ch.list_cycle   <= c.list_cycle;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        p = predict_mix(c);
        pending_words.push_back(typed ? want : p);
    endtask

    task automatic write_reg(logic [mvnsm_pkg::CFG_IDX_W-1:0] idx,
                             logic [mvnsm_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            mvnsm_pkg::REG_BUS_HZ: p_bus_hz = value;
            mvnsm_pkg::REG_PERIOD: p_period = value[mvnsm_pkg::PERIOD_W-1:0];
            mvnsm_pkg::REG_HALVE:  p_halve  = value[mvnsm_pkg::HALVE_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Waits until every expected word has come back, then lets the block settle.
    task automatic drain_results();
        int waited;
        waited = 0;
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (pending_words.size() != 0 && waited < 400000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random command word. Starts read only the written window; queries walk the
    // list position forward in steps scaled to the period so that levels fall due.
    function automatic mvnsm_pkg::cmd_t random_cmd(int unsigned step_max);
        mvnsm_pkg::cmd_t c;
        int pick;
        int base;
        c = '{action: mvnsm_pkg::ACT_STORE,
              address: mvnsm_pkg::ADDR_W'($urandom),
              data_byte: 8'($urandom),
              voice: mvnsm_pkg::VOICE_W'($urandom),
              all_voices: 1'($urandom),
              sample_rate: mvnsm_pkg::RATE_W'($urandom),
              sample_count: mvnsm_pkg::LEN_W'($urandom),
              loop: 1'($urandom),
              list_cycle: mvnsm_pkg::CYC_W'($urandom)};
        pick = $urandom_range(99);
        if (pick < 20)
        begin
            c.action = mvnsm_pkg::ACT_STORE;
            if ($urandom_range(3) != 0)
                c.address = mvnsm_pkg::ADDR_W'($urandom_range(WINDOW - 1));
        end
        else if (pick < 40)
        begin
            c.action = mvnsm_pkg::ACT_START;
            if ($urandom_range(9) == 0)
            begin
                // Rejected start: one of the three faults, everything else random.
                case ($urandom_range(2))
                    0: c.sample_rate = '0;
                    1: c.sample_rate = mvnsm_pkg::RATE_W'($urandom_range(65535, 48001));
                    default: c.sample_count = '0;
                endcase
            end
            else
            begin
                base = $urandom_range(WINDOW - 1);
                c.address = mvnsm_pkg::ADDR_W'(base);
                c.sample_count = mvnsm_pkg::LEN_W'($urandom_range(2 * (WINDOW - base), 1));
                c.sample_rate = ($urandom_range(4) == 0)
                                ? mvnsm_pkg::MAX_RATE
                                : mvnsm_pkg::RATE_W'($urandom_range(48000, 1));
            end
        end
        else if (pick < 47)
            c.action = mvnsm_pkg::ACT_STOP;
        else if (pick < 92)
        begin
            c.action = mvnsm_pkg::ACT_QUERY;
            if ($urandom_range(19) == 0)
                list_pos = mvnsm_pkg::CYC_W'($urandom);
            else
                list_pos = list_pos + mvnsm_pkg::CYC_W'($urandom_range(step_max));
            c.list_cycle = list_pos;
        end
        else if (pick < 97)
        begin
            c.action = mvnsm_pkg::ACT_FRAME;
            if ($urandom_range(3) != 0)
                c.list_cycle = list_pos + mvnsm_pkg::CYC_W'($urandom_range(step_max));
            list_pos = '0;
        end
        else
        begin
            case ($urandom_range(2))
                0: c.action = ACT_SPARE_A;
                1: c.action = ACT_SPARE_B;
                default: c.action = ACT_SPARE_C;
            endcase
        end
        return c;
    endfunction

    task automatic random_phase(int items);
        int unsigned step_max;
        step_max = p_period + p_period / 2 + 50;
        if (step_max > 65535)
            step_max = 65535;
        for (int i = 0; i < items; i++)
            send_cmd(random_cmd(step_max));
    endtask

    // Directed rows: idle query, stores at both ends of the store, the three
    // rejected starts, a voice that plays out, a start reading across the wrap
    // of the store, a restart, a frame end forward and one cut back, a position
    // going backwards, the unknown actions, and stops of one and of all voices.
    directed_row_t directed [] = '{
        '{'{mvnsm_pkg::ACT_QUERY, 14'd0, 8'd0, 3'd0, 1'b0, 16'd0, 16'd0, 1'b0, 16'd100},
          1'b1, '{1'b0, 4'd0, 1'b0, 1'b0}},
        '{'{mvnsm_pkg::ACT_STORE, 14'd0, 8'hF0, 3'd0, 1'b0, 16'd0, 16'd0, 1'b0, 16'd0},
          1'b0, '0},
        '{'{mvnsm_pkg::ACT_STORE, 14'd1, 8'h1E, 3'd0, 1'b0, 16'd0, 16'd0, 1'b0, 16'd0},
          1'b0, '0},
        '{'{mvnsm_pkg::ACT_STORE, 14'h3FFF, 8'hFF, 3'd7, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1,
            16'hFFFF}, 1'b0, '0},
        '{'{mvnsm_pkg::ACT_START, 14'd0, 8'd0, 3'd0, 1'b0, 16'd48000, 16'd4, 1'b0, 16'd0},
          1'b1, '{1'b0, 4'd0, 1'b1, 1'b1}},
        '{'{mvnsm_pkg::ACT_START, 14'h3FFF, 8'd0, 3'd1, 1'b0, 16'd0, 16'd32768, 1'b1,
            16'd0}, 1'b1, '{1'b0, 4'd0, 1'b0, 1'b1}},
        '{'{mvnsm_pkg::ACT_START, 14'd0, 8'd0, 3'd1, 1'b0, 16'd48001, 16'd4, 1'b0, 16'd0},
          1'b1, '{1'b0, 4'd0, 1'b0, 1'b1}},
        '{'{mvnsm_pkg::ACT_START, 14'd0, 8'd0, 3'd1, 1'b0, 16'd100, 16'd0, 1'b0, 16'd0},
          1'b1, '{1'b0, 4'd0, 1'b0, 1'b1}},
        // A list gap of 200 at 48 kHz moves the four-sample voice six places: it ends
        // and the level is the midpoint of the table.
        '{'{mvnsm_pkg::ACT_QUERY, 14'd0, 8'd0, 3'd0, 1'b0, 16'd0, 16'd0, 1'b0, 16'd300},
          1'b1, '{1'b1, 4'd12, 1'b0, 1'b0}},
        '{'{mvnsm_pkg::ACT_START, 14'h3FFF, 8'd0, 3'd7, 1'b0, 16'd1, 16'd4, 1'b1, 16'd0},
          1'b0, '0},
        '{'{mvnsm_pkg::ACT_START, 14'h3FFF, 8'd0, 3'd7, 1'b0, 16'd30000, 16'd4, 1'b1,
            16'd0}, 1'b0, '0},
        '{'{mvnsm_pkg::ACT_START, 14'd0, 8'd0, 3'd3, 1'b0, 16'd48000, 16'd3, 1'b1, 16'd0},
          1'b0, '0},
        '{'{mvnsm_pkg::ACT_FRAME, 14'd0, 8'd0, 3'd3, 1'b0, 16'd0, 16'd0, 1'b0, 16'd500},
          1'b0, '0},
        '{'{mvnsm_pkg::ACT_QUERY, 14'd0, 8'd0, 3'd3, 1'b0, 16'd0, 16'd0, 1'b0, 16'd50},
          1'b0, '0},
        '{'{mvnsm_pkg::ACT_QUERY, 14'd0, 8'd0, 3'd7, 1'b0, 16'd0, 16'd0, 1'b0, 16'd10},
          1'b0, '0},
        '{'{mvnsm_pkg::ACT_QUERY, 14'd0, 8'd0, 3'd7, 1'b0, 16'd0, 16'd0, 1'b0, 16'd400},
          1'b0, '0},
        '{'{mvnsm_pkg::ACT_FRAME, 14'd0, 8'd0, 3'd3, 1'b0, 16'd0, 16'd0, 1'b0, 16'hFFFF},
          1'b0, '0},
        '{'{mvnsm_pkg::ACT_QUERY, 14'd0, 8'd0, 3'd3, 1'b0, 16'd0, 16'd0, 1'b0, 16'd0},
          1'b0, '0},
        '{'{ACT_SPARE_A, 14'h3FFF, 8'hFF, 3'd7, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF},
          1'b0, '0},
        '{'{ACT_SPARE_B, 14'd0, 8'd0, 3'd0, 1'b1, 16'd0, 16'd0, 1'b0, 16'd0}, 1'b0, '0},
        '{'{ACT_SPARE_C, 14'd0, 8'd0, 3'd3, 1'b0, 16'd0, 16'd0, 1'b0, 16'd0}, 1'b0, '0},
        '{'{mvnsm_pkg::ACT_STOP, 14'd0, 8'd0, 3'd3, 1'b0, 16'd0, 16'd0, 1'b0, 16'd0},
          1'b0, '0},
        '{'{mvnsm_pkg::ACT_STOP, 14'd0, 8'd0, 3'd0, 1'b1, 16'd0, 16'd0, 1'b0, 16'd0},
          1'b1, '{1'b0, 4'd0, 1'b0, 1'b0}},
        '{'{mvnsm_pkg::ACT_STOP, 14'd0, 8'd0, 3'd5, 1'b0, 16'd0, 16'd0, 1'b0, 16'd0},
          1'b1, '{1'b0, 4'd0, 1'b0, 1'b0}}
    };

    initial
    begin
        mvnsm_pkg::cmd_t fill;
        clk = 1'b0;
        rst_n = 1'b0;
        mismatches = 0;
        list_pos = '0;
        send_idle_pct = 19;
        recv_stall_pct = 63;
        cmd_ch.valid = 1'b0;
        cmd_ch.action = mvnsm_pkg::ACT_STORE;
        cmd_ch.address = '0;
        cmd_ch.data_byte = '0;
        cmd_ch.voice = '0;
        cmd_ch.all_voices = 1'b0;
        cmd_ch.sample_rate = '0;
        cmd_ch.sample_count = '0;
        cmd_ch.loop = 1'b0;
        cmd_ch.list_cycle = '0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = mvnsm_pkg::REG_BUS_HZ;
        cfg_ch.data = '0;

        // Predictor after reset: defaults loaded, every voice idle.
        p_bus_hz = mvnsm_pkg::BUS_HZ_RST;
        p_period = mvnsm_pkg::PERIOD_RST;
        p_halve = mvnsm_pkg::HALVE_RST;
        for (int v = 0; v < mvnsm_pkg::VOICE_COUNT; v++)
        begin
            p_start[v] = '0;
            p_length[v] = 0;
            p_rate[v] = 0;
            p_cursor[v] = 0;
            p_fraction[v] = 0;
            p_repeat[v] = 0;
            p_active[v] = 0;
        end
        p_active_count = 0;
        p_debt = 0;
        p_last_cycle = 0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // The directed table runs at the reset configuration.
        foreach (directed[i])
            send_cmd(directed[i].c, directed[i].typed, directed[i].want);

        // Fill the window that random voices play from, then the first random
        // phase with the sender idling lightly and the receiver stalling often.
        for (int a = 0; a < WINDOW; a++)
        begin
            fill = '0;
            fill.action = mvnsm_pkg::ACT_STORE;
            fill.address = mvnsm_pkg::ADDR_W'(a);
            fill.data_byte = 8'($urandom);
            send_cmd(fill);
        end
        drain_results();
        write_reg(mvnsm_pkg::REG_BUS_HZ, mvnsm_pkg::CFG_DATA_W'(1500000));
        write_reg(mvnsm_pkg::REG_PERIOD, mvnsm_pkg::CFG_DATA_W'(187));
        write_reg(mvnsm_pkg::REG_HALVE, mvnsm_pkg::CFG_DATA_W'(3));
        random_phase(260);

        // Largest bus rate and period, a halving threshold above the voice count, with the idling turned round.
        drain_results();
        send_idle_pct = 63;
        recv_stall_pct = 19;
        write_reg(mvnsm_pkg::REG_BUS_HZ, mvnsm_pkg::CFG_DATA_W'(16777215));
        write_reg(mvnsm_pkg::REG_PERIOD, mvnsm_pkg::CFG_DATA_W'(65535));
        write_reg(mvnsm_pkg::REG_HALVE, mvnsm_pkg::CFG_DATA_W'(16));
        random_phase(260);

        // Smallest legal settings: voices race and every mix is halved; no idling.
        drain_results();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_reg(mvnsm_pkg::REG_BUS_HZ, mvnsm_pkg::CFG_DATA_W'(1));
        write_reg(mvnsm_pkg::REG_PERIOD, mvnsm_pkg::CFG_DATA_W'(1));
        write_reg(mvnsm_pkg::REG_HALVE, mvnsm_pkg::CFG_DATA_W'(0));
        random_phase(250);

        // A zero modulus acts as one and a zero period makes every busy query due.
        drain_results();
        write_reg(mvnsm_pkg::REG_BUS_HZ, mvnsm_pkg::CFG_DATA_W'(0));
        write_reg(mvnsm_pkg::REG_PERIOD, mvnsm_pkg::CFG_DATA_W'(0));
        write_reg(mvnsm_pkg::REG_HALVE, mvnsm_pkg::CFG_DATA_W'(8));
        random_phase(250);

        drain_results();
        if (mismatches == 0 && pending_words.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
